// ----- rtl/gtg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector package
// Shared widths, command and move codes, register defaults, the history
// control bundle and the response record.
// ----------------------------------------------------------------------------
package gtg_pkg;

   // Field widths fixed by the request and response formats.
   localparam int CMD_W    = 2;
   localparam int GYRO_W   = 16;
   localparam int TIME_W   = 32;
   localparam int MOVE_W   = 3;
   localparam int COUNT_W  = 16;
   localparam int THRESH_W = 15;

   // Configuration port geometry.
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   typedef logic [MOVE_W-1:0] move_type;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UNDO   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

   // Move and event codes.
   localparam move_type MV_STILL = 3'd0;
   localparam move_type MV_UP    = 3'd1;
   localparam move_type MV_DOWN  = 3'd2;
   localparam move_type MV_LEFT  = 3'd3;
   localparam move_type MV_RIGHT = 3'd4;

   // Register indexes, selected by address bit 2.
   localparam logic REG_THRESHOLD  = 1'b0;
   localparam logic REG_REFRACTORY = 1'b1;

   // Register reset values.
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET  = 15'd800;
   localparam logic [TIME_W-1:0]   REFRACTORY_RESET = 32'd10000;

   // Control bundle from the core to the history ring.
   typedef struct packed {
      logic     push;
      logic     undo;
      logic     clear;
      move_type move;
   } hist_ctrl_type;

   // One response record.
   typedef struct packed {
      move_type             event_res;
      move_type             current_move;
      logic [COUNT_W-1:0]   move_total;
   } rsp_type;

   // Opposite direction of a move; still maps to still.
   function automatic move_type opposite(input move_type m);
      move_type r;
      case (m)
         MV_UP:    r = MV_DOWN;
         MV_DOWN:  r = MV_UP;
         MV_LEFT:  r = MV_RIGHT;
         MV_RIGHT: r = MV_LEFT;
         default:  r = MV_STILL;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ----- rtl/gtg_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector channels
// Valid/ready channels for the request stream and the response stream.
// ----------------------------------------------------------------------------
interface gtg_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [gtg_pkg::CMD_W-1:0]            command;
   logic signed [gtg_pkg::GYRO_W-1:0]    gyro_x;
   logic signed [gtg_pkg::GYRO_W-1:0]    gyro_y;
   logic [gtg_pkg::TIME_W-1:0]           timestamp;

   modport source (output valid, command, gyro_x, gyro_y, timestamp, input ready);
   modport sink   (input valid, command, gyro_x, gyro_y, timestamp, output ready);
endinterface

interface gtg_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [gtg_pkg::MOVE_W-1:0]    event_res;
   logic [gtg_pkg::MOVE_W-1:0]    current_move;
   logic [gtg_pkg::COUNT_W-1:0]   move_total;

   modport source (output valid, event_res, current_move, move_total, input ready);
   modport sink   (input valid, event_res, current_move, move_total, output ready);
endinterface
`default_nettype wire

// ----- rtl/gtg_classify.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector classifier
// Two-point smoothing of both axes, refractory check and priority
// classification of the smoothed rates.
// ----------------------------------------------------------------------------
module gtg_classify (
   input  wire logic signed [gtg_pkg::GYRO_W-1:0]   gyro_x,
   input  wire logic signed [gtg_pkg::GYRO_W-1:0]   gyro_y,
   input  wire logic [gtg_pkg::TIME_W-1:0]          timestamp,
   input  wire logic signed [gtg_pkg::GYRO_W-1:0]   smooth_x,
   input  wire logic signed [gtg_pkg::GYRO_W-1:0]   smooth_y,
   input  wire logic [gtg_pkg::TIME_W-1:0]          last_time,
   input  wire logic [gtg_pkg::THRESH_W-1:0]        threshold,
   input  wire logic [gtg_pkg::TIME_W-1:0]          refractory,
   output logic signed [gtg_pkg::GYRO_W-1:0]        smooth_x_new,
   output logic signed [gtg_pkg::GYRO_W-1:0]        smooth_y_new,
   output logic                                     elapsed,
   output gtg_pkg::move_type                        move
);

   logic signed [gtg_pkg::GYRO_W:0] sum_x;
   logic signed [gtg_pkg::GYRO_W:0] sum_y;
   logic signed [gtg_pkg::GYRO_W:0] ext_x;
   logic signed [gtg_pkg::GYRO_W:0] ext_y;
   logic signed [gtg_pkg::GYRO_W:0] thr_pos;
   logic signed [gtg_pkg::GYRO_W:0] thr_neg;
   logic [gtg_pkg::TIME_W-1:0]      delta;

   // The sum keeps one extra bit; dropping its low bit gives the floor average.
   assign sum_x = {gyro_x[gtg_pkg::GYRO_W-1], gyro_x} +
                  {smooth_x[gtg_pkg::GYRO_W-1], smooth_x};
   assign sum_y = {gyro_y[gtg_pkg::GYRO_W-1], gyro_y} +
                  {smooth_y[gtg_pkg::GYRO_W-1], smooth_y};
   assign smooth_x_new = sum_x[gtg_pkg::GYRO_W:1];
   assign smooth_y_new = sum_y[gtg_pkg::GYRO_W:1];

   // Signed compare against the threshold and its negation.
   assign ext_x   = {smooth_x_new[gtg_pkg::GYRO_W-1], smooth_x_new};
   assign ext_y   = {smooth_y_new[gtg_pkg::GYRO_W-1], smooth_y_new};
   assign thr_pos = {2'b00, threshold};
   assign thr_neg = -thr_pos;

   // Time since the last move, modulo the timestamp width.
   assign delta   = timestamp - last_time;
   assign elapsed = (delta > refractory);

   // Priority classification: X before Y, positive before negative.
   always_comb begin
      if (ext_x > thr_pos) begin
         move = gtg_pkg::MV_UP;
      end else if (ext_x < thr_neg) begin
         move = gtg_pkg::MV_DOWN;
      end else if (ext_y > thr_pos) begin
         move = gtg_pkg::MV_RIGHT;
      end else if (ext_y < thr_neg) begin
         move = gtg_pkg::MV_LEFT;
      end else begin
         move = gtg_pkg::MV_STILL;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/gtg_history.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector history ring
// Ring of detected moves with a write pointer, per-entry valid bits and a
// registered view of the newest entry, which undo consumes.
// ----------------------------------------------------------------------------
module gtg_history #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire gtg_pkg::hist_ctrl_type  ctrl,
   output gtg_pkg::move_type            top_move
);

   localparam int PTR_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
   localparam logic [PTR_W-1:0] LAST = PTR_W'(HISTORY_DEPTH - 1);

   gtg_pkg::move_type        mem [HISTORY_DEPTH];
   logic [PTR_W-1:0]         ptr_ff;
   logic [PTR_W-1:0]         ptr_in;
   logic [PTR_W-1:0]         rd_addr;
   logic [HISTORY_DEPTH-1:0] valid_ff;
   logic [HISTORY_DEPTH-1:0] valid_in;
   gtg_pkg::move_type        rd_data_ff;
   logic                     top_valid_ff;
   logic                     bypass_ff;
   gtg_pkg::move_type        bypass_move_ff;

   // Next pointer and valid bits. Undo drops the newest entry by clearing
   // its valid bit; clear drops every entry at once.
   always_comb begin
      ptr_in   = ptr_ff;
      valid_in = valid_ff;
      if (ctrl.clear) begin
         ptr_in   = '0;
         valid_in = '0;
      end else if (ctrl.push) begin
         valid_in[ptr_ff] = 1'b1;
         ptr_in = (ptr_ff == LAST) ? '0 : ptr_ff + 1'b1;
      end else if (ctrl.undo) begin
         ptr_in = (ptr_ff == '0) ? LAST : ptr_ff - 1'b1;
         valid_in[ptr_in] = 1'b0;
      end
   end

   // The newest entry sits one behind the next pointer.
   assign rd_addr = (ptr_in == '0) ? LAST : ptr_in - 1'b1;

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff       <= '0;
         valid_ff     <= '0;
         top_valid_ff <= 1'b0;
         bypass_ff    <= 1'b0;
      end else begin
         ptr_ff       <= ptr_in;
         valid_ff     <= valid_in;
         top_valid_ff <= valid_in[rd_addr];
         bypass_ff    <= ctrl.push;
      end
   end

   // Ring storage with a registered read of the newest entry. A push writes
   // the entry that is read in the same cycle, so its move is bypassed.
   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[ptr_ff] <= ctrl.move;
      end
      rd_data_ff     <= mem[rd_addr];
      bypass_move_ff <= ctrl.move;
   end

   assign top_move = bypass_ff    ? bypass_move_ff :
                     top_valid_ff ? rd_data_ff     : gtg_pkg::MV_STILL;

endmodule
`default_nettype wire

// ----- rtl/gtg_rsp_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector response queue
// Two-entry output buffer: a head register and a skid register, so a new
// request is taken while one response still waits.
// ----------------------------------------------------------------------------
module gtg_rsp_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire gtg_pkg::rsp_type  in_data,
   output logic                   in_ready,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output gtg_pkg::rsp_type       out_data
);

   logic [1:0]       count_ff;
   logic [1:0]       count_in;
   gtg_pkg::rsp_type head_ff;
   gtg_pkg::rsp_type head_in;
   gtg_pkg::rsp_type skid_ff;
   gtg_pkg::rsp_type skid_in;
   logic             push;
   logic             pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = head_ff;
   assign push      = in_valid & in_ready;
   assign pop       = out_valid & out_ready;

   // Next occupancy and contents.
   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      skid_in  = skid_ff;
      case (count_ff)
         2'd0: begin
            if (push) begin
               head_in  = in_data;
               count_in = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = in_data;
            end else if (push) begin
               skid_in  = in_data;
               count_in = 2'd2;
            end else if (pop) begin
               count_in = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in  = skid_ff;
               count_in = 2'd1;
            end
         end
         default: begin
            count_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule
`default_nettype wire

// ----- rtl/gyro_tilt_gesture_detector_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Gyro tilt gesture detector core
// Smooths gyro samples, detects tilt moves after a refractory interval,
// counts them and keeps an undoable history ring.
//
//   Channel   Direction  Handshake                 Carries
//   req_ch    in         valid/ready               command, gyro_x, gyro_y, timestamp
//   rsp_ch    out        valid/ready               event_res, current_move, move_total
//   csr_*     in         APB r/w, pready high      gyro_threshold, refractory_ticks
//
// One request is taken per clock cycle while req_ch.ready is high. All state,
// the response buffer included, updates at the edge a request is taken.
// The two-entry response buffer sets the rate: a stalled response side
// still lets one more request in, then req_ch.ready drops until space frees.
// Reset is synchronous and active high; the history valid bits clear at once.
// ----------------------------------------------------------------------------
module gyro_tilt_gesture_detector_core #(
   parameter int HISTORY_DEPTH = 10
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   gtg_req_if.sink                                 req_ch,
   gtg_rsp_if.source                               rsp_ch,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [gtg_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [gtg_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [gtg_pkg::CSR_DATA_W-1:0]          csr_prdata,
   output logic                                    csr_pready
);

   // Configuration registers.
   logic [gtg_pkg::THRESH_W-1:0]       threshold_ff;
   logic [gtg_pkg::TIME_W-1:0]         refractory_ff;
   logic                               csr_write;

   // Detector state.
   logic signed [gtg_pkg::GYRO_W-1:0]  smooth_x_ff;
   logic signed [gtg_pkg::GYRO_W-1:0]  smooth_y_ff;
   logic signed [gtg_pkg::GYRO_W-1:0]  smooth_x_in;
   logic signed [gtg_pkg::GYRO_W-1:0]  smooth_y_in;
   logic [gtg_pkg::TIME_W-1:0]         last_time_ff;
   logic [gtg_pkg::TIME_W-1:0]         last_time_in;
   gtg_pkg::move_type                  move_now_ff;
   gtg_pkg::move_type                  move_now_in;
   logic [gtg_pkg::COUNT_W-1:0]        counter_ff;
   logic [gtg_pkg::COUNT_W-1:0]        counter_in;

   logic signed [gtg_pkg::GYRO_W-1:0]  smooth_x_new;
   logic signed [gtg_pkg::GYRO_W-1:0]  smooth_y_new;
   logic                               elapsed;
   gtg_pkg::move_type                  move;
   gtg_pkg::move_type                  top_move;
   gtg_pkg::move_type                  event_code;
   gtg_pkg::hist_ctrl_type             hist_ctrl;
   gtg_pkg::rsp_type                   rsp_data;
   gtg_pkg::rsp_type                   rsp_out;
   logic                               accept;

   // Configuration port: address bit 2 selects the register.
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff  <= gtg_pkg::THRESHOLD_RESET;
         refractory_ff <= gtg_pkg::REFRACTORY_RESET;
      end else if (csr_write) begin
         if (csr_paddr[2] == gtg_pkg::REG_REFRACTORY) begin
            refractory_ff <= csr_pwdata;
         end else begin
            threshold_ff <= csr_pwdata[gtg_pkg::THRESH_W-1:0];
         end
      end
   end

   assign csr_prdata = (csr_paddr[2] == gtg_pkg::REG_REFRACTORY) ? refractory_ff :
                       {{(gtg_pkg::CSR_DATA_W - gtg_pkg::THRESH_W){1'b0}}, threshold_ff};

   // Smoothing and classification of the current request.
   gtg_classify u_classify (
      .gyro_x       (req_ch.gyro_x),
      .gyro_y       (req_ch.gyro_y),
      .timestamp    (req_ch.timestamp),
      .smooth_x     (smooth_x_ff),
      .smooth_y     (smooth_y_ff),
      .last_time    (last_time_ff),
      .threshold    (threshold_ff),
      .refractory   (refractory_ff),
      .smooth_x_new (smooth_x_new),
      .smooth_y_new (smooth_y_new),
      .elapsed      (elapsed),
      .move         (move)
   );

   assign accept = req_ch.valid & req_ch.ready;

   // Next state, history control and event for the accepted request.
   always_comb begin
      smooth_x_in     = smooth_x_ff;
      smooth_y_in     = smooth_y_ff;
      last_time_in    = last_time_ff;
      move_now_in     = move_now_ff;
      counter_in      = counter_ff;
      event_code      = gtg_pkg::MV_STILL;
      hist_ctrl.push  = 1'b0;
      hist_ctrl.undo  = 1'b0;
      hist_ctrl.clear = 1'b0;
      hist_ctrl.move  = move;
      if (accept) begin
         case (req_ch.command)
            gtg_pkg::CMD_SAMPLE: begin
               smooth_x_in = smooth_x_new;
               smooth_y_in = smooth_y_new;
               if (elapsed) begin
                  move_now_in = move;
                  if (move != gtg_pkg::MV_STILL) begin
                     event_code     = move;
                     counter_in     = counter_ff + 1'b1;
                     last_time_in   = req_ch.timestamp;
                     hist_ctrl.push = 1'b1;
                  end
               end
            end
            gtg_pkg::CMD_UNDO: begin
               hist_ctrl.undo = 1'b1;
               event_code     = gtg_pkg::opposite(top_move);
            end
            gtg_pkg::CMD_CLEAR: begin
               hist_ctrl.clear = 1'b1;
               counter_in      = '0;
            end
            default: begin
               // The unused command code changes nothing.
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_x_ff  <= '0;
         smooth_y_ff  <= '0;
         last_time_ff <= '0;
         move_now_ff  <= gtg_pkg::MV_STILL;
         counter_ff   <= '0;
      end else begin
         smooth_x_ff  <= smooth_x_in;
         smooth_y_ff  <= smooth_y_in;
         last_time_ff <= last_time_in;
         move_now_ff  <= move_now_in;
         counter_ff   <= counter_in;
      end
   end

   // History ring.
   gtg_history #(
      .HISTORY_DEPTH (HISTORY_DEPTH)
   ) u_history (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (hist_ctrl),
      .top_move (top_move)
   );

   // Response buffer.
   assign rsp_data.event_res    = event_code;
   assign rsp_data.current_move = move_now_in;
   assign rsp_data.move_total   = counter_in;

   gtg_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_data   (rsp_data),
      .in_ready  (req_ch.ready),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_out)
   );

   assign rsp_ch.event_res    = rsp_out.event_res;
   assign rsp_ch.current_move = rsp_out.current_move;
   assign rsp_ch.move_total   = rsp_out.move_total;

`ifndef SYNTHESIS
   // A detected move bumps the counter by one.
   a_push_counts : assert property (@(posedge clock) disable iff (reset)
      hist_ctrl.push |=> counter_ff == 16'($past(counter_ff) + 16'd1))
      else $error("move counter did not advance on a detected move");

   // A detected move records its timestamp.
   a_push_time : assert property (@(posedge clock) disable iff (reset)
      hist_ctrl.push |=> last_time_ff == $past(req_ch.timestamp))
      else $error("last move time not recorded");

   // Undo leaves the counter and the current move alone.
   a_undo_stable : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.command == gtg_pkg::CMD_UNDO) |=>
         ($stable(counter_ff) && $stable(move_now_ff)))
      else $error("undo changed counter or current move");

   // Clear empties the counter.
   a_clear_zero : assert property (@(posedge clock) disable iff (reset)
      (accept && req_ch.command == gtg_pkg::CMD_CLEAR) |=> counter_ff == '0)
      else $error("clear did not empty the counter");
`endif

endmodule
`default_nettype wire
